[rtl/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // stream and config port widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  // item kinds (in_tuser)
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  // bus actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_NOACK   = 3'd2;
  localparam logic [2:0] ACT_ACK     = 3'd3;
  localparam logic [2:0] ACT_STOP    = 3'd4;
  localparam logic [2:0] ACT_RELEASE = 3'd5;

  // TWI status codes
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
  localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
  localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
  localparam logic [7:0] ST_DATA_R_NAK = 8'h58;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_STOP = 2'd3;

  // in_tdata layout, lowest field last
  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] rx_byte;
    logic [7:0] status_code;
    logic [7:0] buf_data;
    logic [4:0] buf_index;
  } in_data_t;

  typedef struct packed {
    logic [1:0] kind;
    in_data_t   data;
  } item_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic       read_not_write;
    logic [5:0] byte_count;
    logic       send_stop;
  } cfg_t;

  typedef struct packed {
    logic [5:0] ptr;
    logic       busy;
    logic [7:0] saved_error;
  } seq_state_t;

  // out_tdata layout, lowest field last
  typedef struct packed {
    logic [3:0] pad;
    logic [7:0] error_status;
    logic       error_flag;
    logic       busy_res;
    logic [7:0] rx_data;
    logic [4:0] rx_index;
    logic       rx_valid;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [2:0] bus_action;
  } result_t;

endpackage

[rtl/i2cms_step.sv]
// ----------------------------------------------------------------------------
// i2cms_step
// Decision logic for one word: next sequencer state and the result word.
// ----------------------------------------------------------------------------
module i2cms_step (
  input  i2cms_pkg::item_t      item,
  input  i2cms_pkg::seq_state_t cur,
  input  i2cms_pkg::cfg_t       cfg,
  input  logic [7:0]            buf_rd,   // tx buffer at cur.ptr, 0 if beyond depth
  output i2cms_pkg::seq_state_t nxt,
  output i2cms_pkg::result_t    res
);
  import i2cms_pkg::*;

  logic [5:0] ptr_inc;
  logic [6:0] ptr_ahead;

  assign ptr_inc = cur.ptr + 6'd1;

  always_comb begin
    nxt = cur;
    res = '0;
    ptr_ahead = 7'd0;
    case (item.kind)
      KIND_START: begin
        nxt.busy = 1'b1;
        res.bus_action = ACT_START;
      end
      KIND_EVENT: begin
        if (cur.busy) begin
          case (item.data.status_code)
            ST_START, ST_RESTART: begin
              res.tx_valid   = 1'b1;
              res.tx_byte    = {cfg.device_address, cfg.read_not_write};
              nxt.ptr        = 6'd0;
              res.bus_action = ACT_NOACK;
            end
            ST_SLA_W_ACK, ST_DATA_W_ACK: begin
              if (cur.ptr < cfg.byte_count) begin
                res.tx_valid   = 1'b1;
                res.tx_byte    = buf_rd;
                nxt.ptr        = ptr_inc;
                res.bus_action = ACT_NOACK;
              end else begin
                res.bus_action = cfg.send_stop ? ACT_STOP : ACT_RELEASE;
                nxt.busy       = 1'b0;
              end
            end
            ST_DATA_R_ACK: begin
              res.rx_valid   = 1'b1;
              res.rx_index   = cur.ptr[4:0];
              res.rx_data    = item.data.rx_byte;
              nxt.ptr        = ptr_inc;
              ptr_ahead      = {1'b0, ptr_inc} + 7'd1;
              res.bus_action = (ptr_ahead < {1'b0, cfg.byte_count}) ? ACT_ACK : ACT_NOACK;
            end
            ST_SLA_R_ACK: begin
              ptr_ahead      = {1'b0, cur.ptr} + 7'd1;
              res.bus_action = (ptr_ahead < {1'b0, cfg.byte_count}) ? ACT_ACK : ACT_NOACK;
            end
            ST_DATA_R_NAK: begin
              res.rx_valid   = 1'b1;
              res.rx_index   = cur.ptr[4:0];
              res.rx_data    = item.data.rx_byte;
              res.bus_action = ACT_STOP;
              nxt.busy       = 1'b0;
            end
            ST_ARB_LOST: begin
              res.bus_action = ACT_START;
            end
            default: begin
              nxt.saved_error = item.data.status_code;
              res.error_flag  = 1'b1;
              res.bus_action  = ACT_RELEASE;
              nxt.busy        = 1'b0;
            end
          endcase
        end
      end
      default: ;  // load is handled by the buffer; unused kind does nothing
    endcase
    res.busy_res     = nxt.busy;
    res.error_status = nxt.saved_error;
  end

endmodule

[rtl/i2c_master_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// The input register takes the word when it is accepted; the result register
// takes the result word from it when the result register is free or drains.
// Throughput: one word per cycle while out_tready does not stall the result;
// the pointer/busy loop through the decision logic and the registered tx
// buffer read (one write, one read a cycle) set that figure.
// Reset: synchronous, active low; clears control, pointer, busy and error
// registers and the config registers, but for send_stop, which resets to 1.
// The tx buffer is not cleared.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer #(
  parameter int BUF_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: buf_index[4:0], buf_data[12:5], status_code[20:13],
  //           rx_byte[28:21], zero pad[31:29]
  // in_tuser: kind[1:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2cms_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [i2cms_pkg::IN_TUSER_W-1:0]  in_tuser,
  // out_tdata: bus_action[2:0], tx_valid[3], tx_byte[11:4], rx_valid[12],
  //            rx_index[17:13], rx_data[25:18], busy_res[26], error_flag[27],
  //            error_status[35:28], zero pad[39:36]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cms_pkg::OUT_TDATA_W-1:0] out_tdata,
  // config write port
  input  logic                              cfg_we,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import i2cms_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  // input stage
  logic       s_valid_r;
  item_t      s_item_r;

  // result stage
  logic       out_valid_r;
  result_t    out_res_r;

  // config and sequencer state
  cfg_t       cfg_r;
  seq_state_t st_r;

  // tx buffer with registered read, always holding the entry at the pointer
  logic [7:0]    mem [BUF_DEPTH];
  logic [7:0]    rd_data_r;

  logic          advance;
  seq_state_t    st_nxt;
  result_t       res_nxt;
  logic [7:0]    buf_rd;
  logic          ptr_ok;
  logic          bidx_ok;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [5:0]    rd_ptr;
  logic [AW-1:0] rd_addr;

  // the input stage moves on when the result register is free or drains
  assign advance   = s_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

  // data beyond depth goes out as zero
  assign ptr_ok = {2'b00, st_r.ptr} < 8'(BUF_DEPTH);
  assign buf_rd = ptr_ok ? rd_data_r : 8'h00;

  i2cms_step u_step (
    .item   (s_item_r),
    .cur    (st_r),
    .cfg    (cfg_r),
    .buf_rd (buf_rd),
    .nxt    (st_nxt),
    .res    (res_nxt)
  );

  // loads beyond depth are dropped
  assign bidx_ok = {3'b000, s_item_r.data.buf_index} < 8'(BUF_DEPTH);
  assign wr_en   = advance && (s_item_r.kind == KIND_LOAD) && bidx_ok;
  assign wr_addr = AW'({3'b000, s_item_r.data.buf_index});

  // prefetch at the pointer the next word will see
  assign rd_ptr  = advance ? st_nxt.ptr : st_r.ptr;
  assign rd_addr = AW'({2'b00, rd_ptr});

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= s_item_r.data.buf_data;
    end
    // forward a load landing on the prefetched entry
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= s_item_r.data.buf_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_tready) begin
        s_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_item_r.kind <= in_tuser;
      s_item_r.data <= in_tdata;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= 7'd0;
      cfg_r.read_not_write <= 1'b0;
      cfg_r.byte_count     <= 6'd0;
      cfg_r.send_stop      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEV_ADDR:  cfg_r.device_address <= cfg_wdata;
        REG_READ:      cfg_r.read_not_write <= cfg_wdata[0];
        REG_COUNT:     cfg_r.byte_count     <= cfg_wdata[5:0];
        REG_SEND_STOP: cfg_r.send_stop      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/i2cms_checker.sv]
// ----------------------------------------------------------------------------
// i2cms_assertions
// Port-level checks for the I2C master transfer sequencer, bound to the top.
// ----------------------------------------------------------------------------
module i2cms_assertions (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [i2cms_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import i2cms_pkg::*;

  result_t res;
  assign res = out_tdata;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // an error ends the transfer
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.error_flag |-> !res.busy_res && res.bus_action == ACT_RELEASE)
    else $error("error word left busy set");

  // a transmitted byte always goes with proceed-without-ack
  a_tx_act: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.tx_valid |-> res.bus_action == ACT_NOACK && !res.rx_valid)
    else $error("tx byte with wrong action");

  // a received byte is acked, nacked or ends with stop
  a_rx_act: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.rx_valid |->
      res.bus_action == ACT_ACK || res.bus_action == ACT_NOACK ||
      res.bus_action == ACT_STOP)
    else $error("rx byte with wrong action");

endmodule

bind i2c_master_transfer_sequencer i2cms_assertions u_i2cms_assertions (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
